### rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, operation codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd6;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the input beat
    logic upd;       // apply push/pop/clear, set result
    logic rd_end;    // read front or back slot
    logic rd_scan;   // read slot at scan position, advance scan
    logic scan_clr;  // restart scan position
    logic take_rd;   // result from read data
    logic fail;      // result: failed read
    logic miss;      // result: find without match
    logic out_load;  // move result into output register
  } bdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            hit;
    logic            scan_more;
    logic            out_free;
  } bdq_stat_t;

endpackage

### rtl/core/bdq_in_if.sv
// ----------------------------------------------------------------------------
// bdq_in_if
// Operation channel: one operation with its key and link per beat.
// ----------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key_word;
  logic [KEY_W-1:0] link_word;

  modport source (output valid, output op, output key_word, output link_word, input ready);
  modport sink   (input valid, input op, input key_word, input link_word, output ready);
  modport mon    (input valid, input op, input key_word, input link_word, input ready);
endinterface

### rtl/core/bdq_out_if.sv
// ----------------------------------------------------------------------------
// bdq_out_if
// Result channel: one result per operation.
// ----------------------------------------------------------------------------
interface bdq_out_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic             found;
  logic [KEY_W-1:0] out_key;
  logic [KEY_W-1:0] out_link;
  logic             evicted;
  logic [CNT_W-1:0] count;
  logic             is_empty;

  modport source (output valid, output status, output found, output out_key,
                  output out_link, output evicted, output count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input found, input out_key,
                  input out_link, input evicted, input count, input is_empty,
                  output ready);
  modport mon    (input valid, input status, input found, input out_key,
                  input out_link, input evicted, input count, input is_empty,
                  input ready);
endinterface

### rtl/core/bdq_cfg_if.sv
// ----------------------------------------------------------------------------
// bdq_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface bdq_cfg_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
  modport mon    (input valid, input capacity, input ready);
endinterface

### rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accepts one operation, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bdq_stat_t stat_i,
  output bdq_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDCAP = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;  // a scan read is in flight

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_READ_FRONT, OP_READ_BACK: begin
            if (stat_i.empty) begin
              cmd_o.fail = 1'b1;
              state_d    = S_DONE;
            end else begin
              cmd_o.rd_end = 1'b1;
              state_d      = S_RDCAP;
            end
          end
          OP_FIND: begin
            cmd_o.scan_clr = 1'b1;
            pend_d         = 1'b0;
            state_d        = S_SCAN;
          end
          default: begin
            cmd_o.upd = 1'b1;
            state_d   = S_DONE;
          end
        endcase
      end
      S_RDCAP: begin
        cmd_o.take_rd = 1'b1;
        state_d       = S_DONE;
      end
      S_SCAN: begin
        if (pend_q && stat_i.hit) begin
          cmd_o.take_rd = 1'b1;
          state_d       = S_DONE;
        end else if (stat_i.scan_more) begin
          cmd_o.rd_scan = 1'b1;
          pend_d        = 1'b1;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/core/bdq_dpath.sv
// ----------------------------------------------------------------------------
// bdq_dpath
// Circular entry store, end pointers, capacity register, result registers.
// ----------------------------------------------------------------------------
module bdq_dpath import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdq_cmd_t         cmd_i,
  output bdq_stat_t        stat_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_cap_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] link_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_status_o,
  output logic             out_found_o,
  output logic [KEY_W-1:0] out_key_o,
  output logic [KEY_W-1:0] out_link_o,
  output logic             out_evicted_o,
  output logic [CNT_W-1:0] out_count_o,
  output logic             out_empty_o
);

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int unsigned CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);
  localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);

  // (base + off) mod DEPTH, off never exceeds DEPTH
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  logic [2*KEY_W-1:0] mem [DEPTH];
  logic [2*KEY_W-1:0] rdata_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, eff_cap;
  logic [CNT_W-1:0] scan_q;
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] key_q, link_q;

  logic             res_status_q, res_found_q, res_evicted_q;
  logic [KEY_W-1:0] res_key_q, res_link_q;
  logic             out_valid_q;

  logic             empty, full, upd_status, upd_evict, we, re;
  logic [IDX_W-1:0] wa, ra, front_inc, front_dec;

  assign eff_cap   = (cap_q == '0) ? ONE_C : ((cap_q > CAP_MAX_C) ? CAP_MAX_C : cap_q);
  assign empty     = (count_q == '0);
  assign full      = !empty && (count_q >= eff_cap);
  assign front_inc = slot_add(front_q, ONE_C);
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);

  // push / pop / clear
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    we         = 1'b0;
    wa         = slot_add(front_q, count_q);
    upd_status = 1'b0;
    upd_evict  = 1'b0;
    case (op_q)
      OP_PUSH_FRONT: begin
        we        = 1'b1;
        wa        = front_dec;
        front_d   = front_dec;
        upd_evict = full;
        if (!full) count_d = count_q + ONE_C;
      end
      OP_PUSH_BACK: begin
        // full: front moves up one, new back lands at old front + count
        we        = 1'b1;
        upd_evict = full;
        if (full) front_d = front_inc;
        else      count_d = count_q + ONE_C;
      end
      OP_POP_FRONT: begin
        if (empty) upd_status = 1'b1;
        else begin
          front_d = front_inc;
          count_d = count_q - ONE_C;
        end
      end
      OP_POP_BACK: begin
        if (empty) upd_status = 1'b1;
        else       count_d = count_q - ONE_C;
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign re = cmd_i.rd_end || cmd_i.rd_scan;
  assign ra = cmd_i.rd_scan ? slot_add(front_q, scan_q) :
              ((op_q == OP_READ_FRONT) ? front_q : slot_add(front_q, count_q - ONE_C));

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && we) mem[wa] <= {key_q, link_q};
    if (re) rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      cap_q       <= CNT_W'(CAP_RESET);
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_cap_i;
      if (cmd_i.upd) begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (cmd_i.scan_clr)     scan_q <= '0;
      else if (cmd_i.rd_scan) scan_q <= scan_q + ONE_C;
      if (cmd_i.out_load)     out_valid_q <= 1'b1;
      else if (out_ready_i)   out_valid_q <= 1'b0;
    end
  end

  // beat and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      key_q  <= key_i;
      link_q <= link_i;
    end
    if (cmd_i.upd || cmd_i.fail || cmd_i.miss) begin
      res_status_q  <= cmd_i.fail || (cmd_i.upd && upd_status);
      res_found_q   <= 1'b0;
      res_evicted_q <= cmd_i.upd && upd_evict;
      res_key_q     <= '0;
      res_link_q    <= '0;
    end else if (cmd_i.take_rd) begin
      res_status_q  <= 1'b0;
      res_found_q   <= (op_q == OP_FIND);
      res_evicted_q <= 1'b0;
      res_key_q     <= rdata_q[2*KEY_W-1:KEY_W];
      res_link_q    <= rdata_q[KEY_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_status_o  <= res_status_q;
      out_found_o   <= res_found_q;
      out_key_o     <= res_key_q;
      out_link_o    <= res_link_q;
      out_evicted_o <= res_evicted_q;
      out_count_o   <= count_q;
      out_empty_o   <= empty;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.op        = op_q;
  assign stat_o.empty     = empty;
  assign stat_o.hit       = (rdata_q[2*KEY_W-1:KEY_W] == key_q);
  assign stat_o.scan_more = (scan_q < count_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### rtl/core/bounded_deque_with_eviction.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_eviction
// Bounded double-ended queue of key/link entries with eviction on full push.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat payload                        handshake
//  -------  ---  ----------------------------------  ------------------
//  in_i     in   op, key_word, link_word             valid && ready
//  res_o    out  status, found, out_key, out_link,   valid && ready
//                evicted, count, is_empty
//  cfg_i    in   capacity                            valid && ready (ready=1)
//
// Push, pop, clear and a read of an empty deque set their result in the
// execute state; other reads read the end slot there and take it in the
// read-capture state; find reads the entry store one slot per cycle from
// front to back and stops at the first match.
// One operation at a time; the sequencer returns to idle as the result is
// loaded into the output register and takes the next beat from there, even
// while that result still waits on ready.
// Reset (rst_ni low, async) empties the deque and sets capacity to 16; the
// entry store itself is not cleared.
// A stalled result holds its register; the sequencer waits until it frees.
// ----------------------------------------------------------------------------
module bounded_deque_with_eviction import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source res_o,
  bdq_cfg_if.sink   cfg_i
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  // capacity writes are always taken
  assign cfg_i.ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_i.valid),
    .cfg_cap_i     (cfg_i.capacity),
    .op_i          (in_i.op),
    .key_i         (in_i.key_word),
    .link_i        (in_i.link_word),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .out_status_o  (res_o.status),
    .out_found_o   (res_o.found),
    .out_key_o     (res_o.out_key),
    .out_link_o    (res_o.out_link),
    .out_evicted_o (res_o.evicted),
    .out_count_o   (res_o.count),
    .out_empty_o   (res_o.is_empty)
  );

endmodule

### rtl/core/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source res_o
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.count) &&
    $stable(res_o.out_key) && $stable(res_o.status))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.is_empty == (res_o.count == '0)))
    else $error("is_empty disagrees with count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.count <= DEPTH))
    else $error("count above depth");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.found |-> !res_o.status && !res_o.evicted)
    else $error("found with failure or eviction");

  // one operation in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second beat taken while busy");

endmodule

bind bounded_deque_with_eviction bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .res_o  (res_o)
);

### tb/sv/bdq_result_checker.sv
// ----------------------------------------------------------------------------
// bdq_result_checker
// Watches the operation, result and capacity channels, keeps its own deque
// model, predicts one result per operation beat and compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module bdq_result_checker import bdq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  bdq_in_if.mon  in_mon,
  bdq_out_if.mon res_mon,
  bdq_cfg_if.mon cfg_mon,
  output int     pending_o,
  output int     mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [KEY_W-1:0] out_key;
    logic [KEY_W-1:0] out_link;
    logic             evicted;
    logic [CNT_W-1:0] count;
    logic             is_empty;
  } deque_result_t;

  // model state
  logic [KEY_W-1:0] key_mem  [DEPTH_DEF];
  logic [KEY_W-1:0] link_mem [DEPTH_DEF];
  int unsigned      deque_front;
  int unsigned      deque_held;
  logic [CNT_W-1:0] capacity_reg;

  deque_result_t    predicted_results [$];
  int               mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Applies one operation to the model and returns the result it produces.
  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0]  op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [KEY_W-1:0] link);
    deque_result_t r;
    int unsigned   limit;
    int unsigned   slot;
    r = '0;
    // 0 behaves as 1, anything past the store depth as the depth
    if (capacity_reg == 0) limit = 1;
    else if (capacity_reg > DEPTH_DEF) limit = DEPTH_DEF;
    else limit = capacity_reg;
    case (op)
      OP_PUSH_FRONT: begin
        if (deque_held >= limit && deque_held > 0) begin
          deque_held--;
          r.evicted = 1'b1;
        end
        deque_front = (deque_front + DEPTH_DEF - 1) % DEPTH_DEF;
        key_mem[deque_front]  = key;
        link_mem[deque_front] = link;
        deque_held++;
      end
      OP_PUSH_BACK: begin
        if (deque_held >= limit && deque_held > 0) begin
          deque_front = (deque_front + 1) % DEPTH_DEF;
          deque_held--;
          r.evicted = 1'b1;
        end
        slot = (deque_front + deque_held) % DEPTH_DEF;
        key_mem[slot]  = key;
        link_mem[slot] = link;
        deque_held++;
      end
      OP_POP_FRONT: begin
        if (deque_held == 0) begin
          r.status = 1'b1;
        end else begin
          deque_front = (deque_front + 1) % DEPTH_DEF;
          deque_held--;
        end
      end
      OP_POP_BACK: begin
        if (deque_held == 0) r.status = 1'b1;
        else deque_held--;
      end
      OP_CLEAR: begin
        deque_held = 0;
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < deque_held; i++) begin
          slot = (deque_front + i) % DEPTH_DEF;
          if (key_mem[slot] == key) begin
            r.found    = 1'b1;
            r.out_key  = key_mem[slot];
            r.out_link = link_mem[slot];
            break;
          end
        end
      end
      OP_READ_FRONT, OP_READ_BACK: begin
        if (deque_held == 0) begin
          r.status = 1'b1;
        end else begin
          slot = (op == OP_READ_FRONT) ? deque_front
                                       : (deque_front + deque_held - 1) % DEPTH_DEF;
          r.out_key  = key_mem[slot];
          r.out_link = link_mem[slot];
        end
      end
    endcase
    r.count    = CNT_W'(deque_held);
    r.is_empty = (deque_held == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst_ni) begin
      foreach (key_mem[i]) begin
        key_mem[i]  = '0;
        link_mem[i] = '0;
      end
      deque_front  = 0;
      deque_held   = 0;
      capacity_reg = CNT_W'(CAP_RESET);
      predicted_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) capacity_reg = cfg_mon.capacity;
      if (in_mon.valid && in_mon.ready)
        predicted_results.insert(predicted_results.size(),
                                 apply_deque_op(in_mon.op, in_mon.key_word,
                                                in_mon.link_word));
      if (res_mon.valid && res_mon.ready) begin
        got = '{status: res_mon.status, found: res_mon.found, out_key: res_mon.out_key,
                out_link: res_mon.out_link, evicted: res_mon.evicted,
                count: res_mon.count, is_empty: res_mon.is_empty};
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat expected none actual %h", $time, got);
          mismatches++;
        end else begin
          want = predicted_results[0];
          predicted_results.delete(0);
          check_field("status",   want.status,   got.status);
          check_field("found",    want.found,    got.found);
          check_field("out_key",  want.out_key,  got.out_key);
          check_field("out_link", want.out_link, got.out_link);
          check_field("evicted",  want.evicted,  got.evicted);
          check_field("count",    want.count,    got.count);
          check_field("is_empty", want.is_empty, got.is_empty);
        end
      end
      pending_o <= predicted_results.size();
    end
  end

endmodule

### tb/sv/bounded_deque_with_eviction_test.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_eviction_test
// Drives operation beats and capacity writes into the deque, stalls the result
// channel at random, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module bounded_deque_with_eviction_test import bdq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ALT  = {32{2'b01}};   // 0x5555...
  localparam logic [KEY_W-1:0] LINK_ALT = {32{2'b10}};   // 0xAAAA...
  localparam int unsigned      PHASE_OPS = 160;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;   // high: neither side idles
  int   pending;
  int   mismatch_count;

  bdq_in_if  in_if  ();
  bdq_out_if res_if ();
  bdq_cfg_if cfg_if ();

  bounded_deque_with_eviction DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  bdq_result_checker result_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_if),
    .res_mon          (res_if),
    .cfg_mon          (cfg_if),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: back-pressure at random about 22 percent of the time, none while steady.
  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(99) >= 22);
  end

  // One operation beat. Random idle cycles go ahead of the beat unless steady; valid stays
  // high across back-to-back beats so it never toggles within one step.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [KEY_W-1:0] link);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.key_word  <= key;
    in_if.link_word <= link;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Capacity write; only called with the deque idle.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random phase at one capacity. Keys come mostly from a small pool so that
  // finds hit, duplicate keys pile up and pushes run into eviction.
  task automatic run_random_phase(input logic [CNT_W-1:0] cap, input int unsigned n);
    logic [KEY_W-1:0] key_pool [6];
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
    int unsigned      pick;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    drain_results();
    write_capacity(cap);
    repeat (n) begin
      pick = $urandom_range(99);
      // pushes outweigh pops so the deque fills and evicts
      if (pick < 20)      op = OP_PUSH_FRONT;
      else if (pick < 40) op = OP_PUSH_BACK;
      else if (pick < 50) op = OP_POP_FRONT;
      else if (pick < 60) op = OP_POP_BACK;
      else if (pick < 62) op = OP_CLEAR;
      else if (pick < 80) op = OP_FIND;
      else if (pick < 90) op = OP_READ_FRONT;
      else                op = OP_READ_BACK;
      key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(5)] : {$urandom, $urandom};
      send_op(op, key, {$urandom, $urandom});
    end
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_PUSH_FRONT;
    in_if.key_word  <= '0;
    in_if.link_word <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.capacity <= '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: empty deque, capacity at reset value ---
    send_op(OP_READ_FRONT, '0, '0);        // fails on empty
    send_op(OP_READ_BACK,  '0, '0);
    send_op(OP_POP_FRONT,  '0, '0);
    send_op(OP_POP_BACK,   '0, '0);
    send_op(OP_FIND,       '0, '0);        // empty find: success, no match

    // field extremes, duplicate key 0 so find must return the front-most one
    send_op(OP_PUSH_BACK,  KEY_ONES, '0);
    send_op(OP_PUSH_FRONT, '0, KEY_ONES);
    send_op(OP_PUSH_BACK,  KEY_ALT, LINK_ALT);
    send_op(OP_PUSH_BACK,  '0, LINK_ALT);
    send_op(OP_FIND,       '0, '0);
    send_op(OP_FIND,       KEY_ONES, '0);
    send_op(OP_FIND,       LINK_ALT, '0);  // no match
    send_op(OP_READ_FRONT, '0, '0);
    send_op(OP_READ_BACK,  '0, '0);
    send_op(OP_POP_FRONT,  '0, '0);
    send_op(OP_POP_BACK,   '0, '0);
    send_op(OP_CLEAR,      '0, '0);        // front index kept, count to zero
    send_op(OP_READ_BACK,  '0, '0);

    // capacity 1: each push after the first evicts the opposite end
    drain_results();
    write_capacity(CNT_W'(1));
    send_op(OP_PUSH_FRONT, KEY_ALT, KEY_ONES);
    send_op(OP_PUSH_FRONT, KEY_ONES, KEY_ALT);
    send_op(OP_PUSH_BACK,  LINK_ALT, '0);
    send_op(OP_READ_BACK,  '0, '0);

    // capacity 0 acts as 1
    drain_results();
    write_capacity('0);
    send_op(OP_PUSH_BACK,  KEY_ALT, LINK_ALT);

    // out-of-range capacity acts as full depth, then lower it below the count
    drain_results();
    write_capacity(CNT_W'(31));
    send_op(OP_PUSH_BACK,  KEY_ONES, KEY_ONES);
    send_op(OP_PUSH_FRONT, LINK_ALT, KEY_ALT);
    drain_results();
    write_capacity(CNT_W'(2));
    send_op(OP_PUSH_FRONT, '0, KEY_ONES);  // evicts, count stays at 3
    send_op(OP_PUSH_BACK,  KEY_ALT, '0);

    // --- random phases over a spread of capacities ---
    run_random_phase(CNT_W'(16), PHASE_OPS);
    run_random_phase(CNT_W'(1), PHASE_OPS);
    run_random_phase(CNT_W'(4), PHASE_OPS);
    steady = 1'b1;                        // long stretch with no idle cycles
    run_random_phase(CNT_W'(16), PHASE_OPS);
    steady = 1'b0;
    run_random_phase(CNT_W'($urandom_range(2, 15)), PHASE_OPS);
    run_random_phase('0, PHASE_OPS);
    run_random_phase(CNT_W'(31), PHASE_OPS);
    run_random_phase(CNT_W'(3), PHASE_OPS);  // likely lowered below the count
    run_random_phase(CNT_W'($urandom_range(17, 30)), PHASE_OPS);
    run_random_phase(CNT_W'(8), PHASE_OPS);
    run_random_phase(CNT_W'(2), PHASE_OPS);
    run_random_phase(CNT_W'($urandom_range(1, 16)), PHASE_OPS);

    drain_results();
    repeat (24) @(posedge clk_i);

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5ms;
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_in_if.sv
rtl/core/bdq_out_if.sv
rtl/core/bdq_cfg_if.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dpath.sv
rtl/core/bounded_deque_with_eviction.sv
rtl/core/bdq_checker.sv
tb/sv/bdq_result_checker.sv
tb/sv/bounded_deque_with_eviction_test.sv
